/* design/stsu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsu_pkg
// Shared types and constants of the slot table nearest-sum search unit.
// ----------------------------------------------------------------------------
package stsu_pkg;

   localparam int SLOTS       = 64;
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int SUM_W       = 18;
   localparam int DIFF_W      = SUM_W + 1;
   localparam int COUNT_W     = 10;
   localparam int LEN_W       = 11;
   localparam int MAX_BLOCK   = 1024;
   localparam int LEN_RESET   = 16;
   localparam int ACTION_W    = 2;
   localparam int BYTE_W      = 8;
   localparam int IDX_W       = 6;
   localparam int STATUS_W    = 2;
   localparam int RSLOT_W     = 6;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_QUERY  = 2'd2,
      ACT_UNUSED = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 2'd0,
      ST_FULL     = 2'd1,
      ST_FOUND    = 2'd2,
      ST_NONE     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_SCAN,
      S_Q_LOAD,
      S_Q_SCAN,
      S_Q_DRAIN,
      S_DONE_RES,
      S_DONE_QRY
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic byte_add;
      logic remove;
      logic q_start;
      logic tgt_load;
      logic scan_init;
      logic scan_step;
      logic ins_step;
      logic out_load;
      logic out_sel_qry;
   } stsu_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_byte;
      logic q_ok;
      logic free_hit;
      logic scan_last;
      logic out_free;
   } stsu_sts_type;

endpackage

/* design/stsu_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsu_req_if / stsu_rsp_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface stsu_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        action;
   logic signed [7:0] data_byte;
   logic [5:0]        slot_index;

   modport source (output valid, output action, output data_byte, output slot_index,
                   input ready);
   modport sink   (input valid, input action, input data_byte, input slot_index,
                   output ready);
endinterface

interface stsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [5:0] result_slot;

   modport source (output valid, output status, output result_slot, input ready);
   modport sink   (input valid, input status, input result_slot, output ready);
endinterface

/* design/stsu_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsu_ctrl
// Controller: sequences byte accumulation, the free-slot scan, the query scan
// and the hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module stsu_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_action,
   output logic                  req_ready,
   input  stsu_pkg::stsu_sts_type sts,
   output stsu_pkg::stsu_cmd_type cmd
);
   import stsu_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_INSERT: begin
                     if (sts.last_byte) state_in = S_INS_SCAN;
                  end
                  ACT_QUERY: begin
                     state_in = sts.q_ok ? S_Q_LOAD : S_DONE_RES;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_INS_SCAN: begin
            if (sts.free_hit || sts.scan_last) state_in = S_DONE_RES;
         end
         S_Q_LOAD:  state_in = S_Q_SCAN;
         S_Q_SCAN: begin
            if (sts.scan_last) state_in = S_Q_DRAIN;
         end
         S_Q_DRAIN: state_in = S_DONE_QRY;
         S_DONE_RES, S_DONE_QRY: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_INSERT: begin
                     cmd.byte_add  = 1'b1;
                     cmd.scan_init = sts.last_byte;
                  end
                  ACT_REMOVE: cmd.remove  = 1'b1;
                  ACT_QUERY:  cmd.q_start = 1'b1;
                  default: cmd = '0;
               endcase
            end
         end
         S_INS_SCAN: cmd.ins_step = 1'b1;
         S_Q_LOAD: begin
            cmd.tgt_load  = 1'b1;
            cmd.scan_init = 1'b1;
         end
         S_Q_SCAN:   cmd.scan_step = 1'b1;
         S_DONE_RES: cmd.out_load  = sts.out_free;
         S_DONE_QRY: begin
            cmd.out_load    = sts.out_free;
            cmd.out_sel_qry = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

endmodule

/* design/stsu_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsu_datapath
// Slot valid bits, slot sum memory, block accumulator, scan counter, nearest
// sum compare stage and the result output register.
// ----------------------------------------------------------------------------
module stsu_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  stsu_pkg::stsu_cmd_type         cmd,
   output stsu_pkg::stsu_sts_type         sts,
   input  logic [stsu_pkg::LEN_W-1:0]     csr_write_data,
   input  logic                          csr_write_enable,
   input  logic signed [stsu_pkg::BYTE_W-1:0] req_data_byte,
   input  logic [stsu_pkg::IDX_W-1:0]     req_slot_index,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [stsu_pkg::STATUS_W-1:0]  rsp_status,
   output logic [stsu_pkg::RSLOT_W-1:0]   rsp_result_slot
);
   import stsu_pkg::*;

   // Configuration and block accumulation.
   logic [LEN_W-1:0]          len_ff;
   logic [LEN_W-1:0]          eff_len;
   logic signed [SUM_W-1:0]   pending_ff;
   logic [COUNT_W-1:0]        count_ff;

   // Table state.
   logic [SLOTS-1:0]          valid_ff;
   logic signed [SUM_W-1:0]   mem [SLOTS];
   logic signed [SUM_W-1:0]   rd_data_ff;
   logic [SLOT_W-1:0]         rd_addr;
   logic                      mem_re;
   logic                      mem_we;

   // Scan and query state.
   logic [SLOT_W-1:0]         cnt_ff;
   logic [SLOT_W-1:0]         qidx_ff;
   logic [SLOT_W-1:0]         req_idx;
   logic signed [SUM_W-1:0]   target_ff;
   logic                      cmp_vld_ff;
   logic                      cmp_vld_in;
   logic                      cmp_slot_vld_ff;
   logic [SLOT_W-1:0]         cmp_idx_ff;
   logic                      found_ff;
   logic [SLOT_W-1:0]         best_ff;
   logic [DIFF_W-1:0]         best_diff_ff;
   logic signed [DIFF_W-1:0]  diff;
   logic [DIFF_W-1:0]         abs_diff;
   logic                      better;

   // Result held for the output register.
   status_type                res_status_ff;
   logic [SLOT_W-1:0]         res_slot_ff;
   logic                      rsp_valid_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic [RSLOT_W-1:0]        rsp_slot_ff;

   assign req_idx = SLOT_W'(req_slot_index);

   always_comb begin
      if (len_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (len_ff > LEN_W'(MAX_BLOCK)) begin
         eff_len = LEN_W'(MAX_BLOCK);
      end else begin
         eff_len = len_ff;
      end
   end

   assign sts.last_byte = ((LEN_W'(count_ff) + LEN_W'(1)) >= eff_len);
   assign sts.q_ok      = (32'(req_slot_index) < SLOTS) && valid_ff[req_idx];
   assign sts.free_hit  = !valid_ff[cnt_ff];
   assign sts.scan_last = (cnt_ff == SLOT_W'(SLOTS - 1));
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_W'(LEN_RESET);
      end else if (csr_write_enable) begin
         len_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         count_ff   <= '0;
      end else if (cmd.byte_add) begin
         pending_ff <= pending_ff + SUM_W'(req_data_byte);
         count_ff   <= count_ff + COUNT_W'(1);
      end else if (cmd.ins_step && (sts.free_hit || sts.scan_last)) begin
         pending_ff <= '0;
         count_ff   <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.remove && (32'(req_slot_index) < SLOTS)) begin
         valid_ff[req_idx] <= 1'b0;
      end else if (mem_we) begin
         valid_ff[cnt_ff] <= 1'b1;
      end
   end

   assign mem_we  = cmd.ins_step && sts.free_hit;
   assign mem_re  = cmd.q_start || cmd.scan_step;
   assign rd_addr = cmd.q_start ? req_idx : cnt_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cnt_ff] <= pending_ff;
      end
      if (mem_re) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         cnt_ff <= '0;
      end else if (cmd.scan_step || (cmd.ins_step && !sts.free_hit && !sts.scan_last)) begin
         cnt_ff <= cnt_ff + SLOT_W'(1);
      end
   end

   // Compare stage: one slot sum per cycle against the target.
   assign cmp_vld_in = cmd.scan_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_step) begin
         cmp_idx_ff      <= cnt_ff;
         cmp_slot_vld_ff <= valid_ff[cnt_ff];
      end
      if (cmd.q_start) begin
         qidx_ff <= req_idx;
      end
      if (cmd.tgt_load) begin
         target_ff <= rd_data_ff;
      end
   end

   assign diff     = DIFF_W'(target_ff) - DIFF_W'(rd_data_ff);
   assign abs_diff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
   // Strict less-than keeps the lowest index on a tie.
   assign better   = cmp_vld_ff && cmp_slot_vld_ff && (cmp_idx_ff != qidx_ff)
                     && (!found_ff || (abs_diff < best_diff_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.tgt_load) begin
         found_ff <= 1'b0;
      end else if (better) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (better) begin
         best_ff      <= cmp_idx_ff;
         best_diff_ff <= abs_diff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.q_start && !sts.q_ok) begin
         res_status_ff <= ST_NONE;
         res_slot_ff   <= '0;
      end else if (cmd.ins_step && sts.free_hit) begin
         res_status_ff <= ST_INSERTED;
         res_slot_ff   <= cnt_ff;
      end else if (cmd.ins_step && sts.scan_last) begin
         res_status_ff <= ST_FULL;
         res_slot_ff   <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (cmd.out_sel_qry) begin
            rsp_status_ff <= found_ff ? ST_FOUND : ST_NONE;
            rsp_slot_ff   <= found_ff ? RSLOT_W'(best_ff) : '0;
         end else begin
            rsp_status_ff <= res_status_ff;
            rsp_slot_ff   <= RSLOT_W'(res_slot_ff);
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_slot = rsp_slot_ff;

endmodule

/* design/slot_table_nearest_sum_search_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_table_nearest_sum_search_unit
// Table of 64 block sums with insert, remove and nearest-sum query.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake              Payload
//  req       in   valid/ready            action, data_byte, slot_index
//  rsp       out  valid/ready            status, result_slot
//  csr       in   write enable, no wait  block_length (11 bits)
//
// An insert byte that does not end its block, a remove and an unused action
// are each taken in the idle state and give no result. The byte that ends a
// block starts a free-slot scan of one valid bit per cycle over up to 64
// slots, then posts the item. A query reads the queried slot's sum, then each
// slot sum in turn through the memory's single read port, then drains.
// Reset is synchronous and clears the valid bits; no clearing pass is needed.
// A stalled result waits in the output register; items that give no result
// are still taken, and the next result waits until the register frees.
// ----------------------------------------------------------------------------
module slot_table_nearest_sum_search_unit (
   input  logic                          clock,
   input  logic                          reset,
   stsu_req_if.sink                      req,
   stsu_rsp_if.source                    rsp,
   input  logic                          csr_write_enable,
   input  logic [stsu_pkg::LEN_W-1:0]     csr_write_data
);
   import stsu_pkg::*;

   stsu_cmd_type cmd;
   stsu_sts_type sts;

   stsu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_action (req.action),
      .req_ready  (req.ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   stsu_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_write_data   (csr_write_data),
      .csr_write_enable (csr_write_enable),
      .req_data_byte    (req.data_byte),
      .req_slot_index   (req.slot_index),
      .rsp_ready        (rsp.ready),
      .rsp_valid        (rsp.valid),
      .rsp_status       (rsp.status),
      .rsp_result_slot  (rsp.result_slot)
   );

endmodule
